// ===== hw/rtl/pre_pkg.sv =====
package pre_pkg;

    // Field and datapath widths
    localparam int POS_W    = 32;
    localparam int QUAT_W   = 16;
    localparam int DT_W     = 20;
    localparam int GAIN_W   = 16;
    localparam int OUT_W    = 32;
    localparam int DIFF_W   = 34;
    localparam int MUL_W    = 70;
    localparam int MUL_B_W  = 20;
    localparam int LEN_W    = 5;
    localparam int ACC_W    = 50;
    localparam int QUOT_W   = 34;
    localparam int DIV_NUM_W = 52;
    localparam int TERM_W   = 33;

    localparam int IN_TDATA_W  = 184;
    localparam int OUT_TDATA_W = 192;

    localparam int NUM_CH   = 7;
    localparam int CH_W     = 3;

    // Microseconds per second, the scale of the differenced term
    localparam logic [MUL_B_W-1:0] US_PER_S = MUL_B_W'(1000000);

    // Configuration register indexes
    localparam logic [2:0] REG_XY_GAIN_NEW  = 3'd0;
    localparam logic [2:0] REG_XY_GAIN_OLD  = 3'd1;
    localparam logic [2:0] REG_Z_GAIN_NEW   = 3'd2;
    localparam logic [2:0] REG_Z_GAIN_OLD   = 3'd3;
    localparam logic [2:0] REG_ROT_GAIN_NEW = 3'd4;
    localparam logic [2:0] REG_ROT_GAIN_OLD = 3'd5;
    localparam logic [2:0] REG_MIN_INTERVAL = 3'd6;

    localparam logic [GAIN_W-1:0] GAIN_NEW_RST = GAIN_W'(58982);
    localparam logic [GAIN_W-1:0] GAIN_OLD_RST = GAIN_W'(6554);
    localparam logic [DT_W-1:0]   MIN_INTERVAL_RST = DT_W'(100);

    // Request to the shift-add multiplier
    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] len;
    } mul_ctl_t;

    // One entry of the rate matrix W(q): negate flag and quaternion index
    typedef struct packed {
        logic       neg;
        logic [1:0] idx;
    } w_ent_t;

    function automatic w_ent_t w_entry(input logic [1:0] row, input logic [1:0] col);
        w_ent_t e;
        case ({row, col})
            4'b00_00: e = '{neg: 1'b1, idx: 2'd1};
            4'b00_01: e = '{neg: 1'b0, idx: 2'd0};
            4'b00_10: e = '{neg: 1'b1, idx: 2'd3};
            4'b00_11: e = '{neg: 1'b0, idx: 2'd2};
            4'b01_00: e = '{neg: 1'b1, idx: 2'd2};
            4'b01_01: e = '{neg: 1'b0, idx: 2'd3};
            4'b01_10: e = '{neg: 1'b0, idx: 2'd0};
            4'b01_11: e = '{neg: 1'b1, idx: 2'd1};
            4'b10_00: e = '{neg: 1'b1, idx: 2'd3};
            4'b10_01: e = '{neg: 1'b1, idx: 2'd2};
            4'b10_10: e = '{neg: 1'b0, idx: 2'd1};
            4'b10_11: e = '{neg: 1'b0, idx: 2'd0};
            default:  e = '{neg: 1'b0, idx: 2'd0};
        endcase
        return e;
    endfunction

    // Arithmetic shift right that rounds toward zero
    function automatic logic signed [MUL_W-1:0] trunc_shr(
        input logic signed [MUL_W-1:0] x,
        input int unsigned             sh
    );
        logic signed [MUL_W-1:0] bias;
        bias = x[MUL_W-1] ? ((MUL_W'(1) << sh) - MUL_W'(1)) : '0;
        return (x + bias) >>> sh;
    endfunction

    // Clamp to 32-bit signed
    function automatic logic [OUT_W-1:0] sat32(input logic signed [MUL_W-1:0] x);
        logic fits;
        fits = (x[MUL_W-1:OUT_W-1] == '0) || (x[MUL_W-1:OUT_W-1] == '1);
        if (fits)
            return x[OUT_W-1:0];
        else if (x[MUL_W-1])
            return {1'b1, {(OUT_W-1){1'b0}}};
        else
            return {1'b0, {(OUT_W-1){1'b1}}};
    endfunction

endpackage

// ===== hw/rtl/pre_mul.sv =====
// Shift-add multiplier: one multiplier bit per cycle, LSB first.
module pre_mul (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pre_pkg::mul_ctl_t                    ctl,
    input  logic signed [pre_pkg::MUL_W-1:0]     a,
    input  logic [pre_pkg::MUL_B_W-1:0]          b,
    output logic                                 busy,
    output logic signed [pre_pkg::MUL_W-1:0]     prod
);

    logic                                busy_reg;
    logic [pre_pkg::LEN_W-1:0]           cnt_reg;
    logic signed [pre_pkg::MUL_W-1:0]    acc_reg;
    logic signed [pre_pkg::MUL_W-1:0]    a_sh_reg;
    logic [pre_pkg::MUL_B_W-1:0]         b_sh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= ctl.len;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - pre_pkg::LEN_W'(1);
            if (cnt_reg == pre_pkg::LEN_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            acc_reg  <= '0;
            a_sh_reg <= a;
            b_sh_reg <= b;
        end
        else if (busy_reg)
        begin
            // add the shifted multiplicand where the multiplier bit is set
            if (b_sh_reg[0])
                acc_reg <= acc_reg + a_sh_reg;
            a_sh_reg <= a_sh_reg <<< 1;
            b_sh_reg <= b_sh_reg >> 1;
        end
    end

    assign busy = busy_reg;
    assign prod = acc_reg;

endmodule

// ===== hw/rtl/pre_div.sv =====
// Restoring divider: one quotient bit per cycle, quotient clamped to all ones.
module pre_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [pre_pkg::DIV_NUM_W-1:0]     num,
    input  logic [pre_pkg::DT_W-1:0]          den,
    output logic                              busy,
    output logic [pre_pkg::QUOT_W-1:0]        quot
);

    logic                             busy_reg;
    logic [5:0]                       cnt_reg;
    logic [pre_pkg::DT_W-1:0]         rem_reg;
    logic [pre_pkg::QUOT_W-1:0]       work_reg;

    logic [pre_pkg::DT_W:0]           trial;
    logic                             ge;
    logic [pre_pkg::DT_W:0]           diff;
    logic                             ovf;

    assign ovf   = pre_pkg::DT_W'(num[pre_pkg::DIV_NUM_W-1:pre_pkg::QUOT_W]) >= den;
    assign trial = {rem_reg, work_reg[pre_pkg::QUOT_W-1]};
    assign ge    = trial >= {1'b0, den};
    assign diff  = trial - {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= !ovf;
            cnt_reg  <= 6'(pre_pkg::QUOT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= pre_pkg::DT_W'(num[pre_pkg::DIV_NUM_W-1:pre_pkg::QUOT_W]);
            // on overflow the result saturates downstream anyway
            work_reg <= ovf ? '1 : num[pre_pkg::QUOT_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[pre_pkg::DT_W-1:0] : trial[pre_pkg::DT_W-1:0];
            work_reg <= {work_reg[pre_pkg::QUOT_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quot = work_reg;

endmodule

// ===== hw/rtl/pose_rate_estimator_unit.sv =====
// One item at a time: s_tready is high only in the idle state, and a stalled output holds
// the unit in its output state. A divide whose quotient overflows is skipped and clamps it.
// A running channel takes a 16-bit and a 20-bit shift-add pass, a 34-step divide and a
// 16-bit pass; the body rate takes twelve 16-bit passes.
// Reset (rst_n, async low) clears control, stored rates, first-sample flag; loads defaults.
module pose_rate_estimator_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z, interval_us, 4 pad bits
    input  logic [pre_pkg::IN_TDATA_W-1:0]         s_tdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // vel_x, vel_y, vel_z, rate_x, rate_y, rate_z
    output logic [pre_pkg::OUT_TDATA_W-1:0]        m_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic                                   cfg_wr_en,
    input  logic [2:0]                             cfg_index,
    input  logic [pre_pkg::DT_W-1:0]               cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CH     = 4'd1;
    localparam logic [3:0] S_MUL1   = 4'd2;
    localparam logic [3:0] S_MUL2   = 4'd3;
    localparam logic [3:0] S_DIV    = 4'd4;
    localparam logic [3:0] S_MUL3   = 4'd5;
    localparam logic [3:0] S_SUM    = 4'd6;
    localparam logic [3:0] S_RSTART = 4'd7;
    localparam logic [3:0] S_RMUL   = 4'd8;
    localparam logic [3:0] S_RFIN   = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    localparam int MW = pre_pkg::MUL_W;

    // Configuration registers
    logic [pre_pkg::GAIN_W-1:0] xy_gain_new_reg, xy_gain_old_reg;
    logic [pre_pkg::GAIN_W-1:0] z_gain_new_reg, z_gain_old_reg;
    logic [pre_pkg::GAIN_W-1:0] rot_gain_new_reg, rot_gain_old_reg;
    logic [pre_pkg::DT_W-1:0]   min_interval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xy_gain_new_reg  <= pre_pkg::GAIN_NEW_RST;
            xy_gain_old_reg  <= pre_pkg::GAIN_OLD_RST;
            z_gain_new_reg   <= pre_pkg::GAIN_NEW_RST;
            z_gain_old_reg   <= pre_pkg::GAIN_OLD_RST;
            rot_gain_new_reg <= pre_pkg::GAIN_NEW_RST;
            rot_gain_old_reg <= pre_pkg::GAIN_OLD_RST;
            min_interval_reg <= pre_pkg::MIN_INTERVAL_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                pre_pkg::REG_XY_GAIN_NEW:  xy_gain_new_reg  <= cfg_data[pre_pkg::GAIN_W-1:0];
                pre_pkg::REG_XY_GAIN_OLD:  xy_gain_old_reg  <= cfg_data[pre_pkg::GAIN_W-1:0];
                pre_pkg::REG_Z_GAIN_NEW:   z_gain_new_reg   <= cfg_data[pre_pkg::GAIN_W-1:0];
                pre_pkg::REG_Z_GAIN_OLD:   z_gain_old_reg   <= cfg_data[pre_pkg::GAIN_W-1:0];
                pre_pkg::REG_ROT_GAIN_NEW: rot_gain_new_reg <= cfg_data[pre_pkg::GAIN_W-1:0];
                pre_pkg::REG_ROT_GAIN_OLD: rot_gain_old_reg <= cfg_data[pre_pkg::GAIN_W-1:0];
                pre_pkg::REG_MIN_INTERVAL: min_interval_reg <= cfg_data;
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    // Control state
    logic [3:0]               state_reg, state_next;
    logic [pre_pkg::CH_W-1:0] k_reg;
    logic [1:0]               i_reg, j_reg;
    logic                     seen_first_reg;
    logic                     first_reg, run_reg;
    logic                     m_tvalid_reg;

    // Latched item and history
    logic signed [pre_pkg::POS_W-1:0]  pos_reg [3];
    logic signed [pre_pkg::QUAT_W-1:0] q_reg [4];
    logic [pre_pkg::DT_W-1:0]          dt_reg;
    logic signed [pre_pkg::POS_W-1:0]  last_pos_reg [3];
    logic signed [pre_pkg::QUAT_W-1:0] last_q_reg [4];
    // channels 0..2 are velocities, 3..6 quaternion rates w,x,y,z
    logic signed [pre_pkg::OUT_W-1:0]  last_rate_reg [pre_pkg::NUM_CH];
    logic signed [pre_pkg::OUT_W-1:0]  new_rate_reg [pre_pkg::NUM_CH];

    // Per-channel working values
    logic                              neg_reg;
    logic [pre_pkg::QUOT_W-1:0]        res_reg;
    logic signed [pre_pkg::TERM_W-1:0] old_term_reg;
    logic signed [pre_pkg::ACC_W-1:0]  acc_reg;
    logic signed [pre_pkg::OUT_W-1:0]  body_rate_reg [3];

    // Output register
    logic [pre_pkg::OUT_W-1:0] out_vel_reg [3];
    logic [pre_pkg::OUT_W-1:0] out_rate_reg [3];

    // Multiplier and divider
    pre_pkg::mul_ctl_t          mul_ctl;
    logic signed [MW-1:0]       mul_a;
    logic [pre_pkg::MUL_B_W-1:0] mul_b;
    logic                       mul_busy;
    logic signed [MW-1:0]       mul_prod;
    logic                       div_start;
    logic                       div_busy;
    logic [pre_pkg::QUOT_W-1:0] div_quot;

    pre_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .prod  (mul_prod)
    );

    pre_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mul_prod[pre_pkg::DIV_NUM_W+15:16]),
        .den   (dt_reg),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // Difference of the current channel: position, or quaternion scaled to Q16.16
    logic signed [pre_pkg::QUAT_W-1:0] lq_w, lq_k, q_k;
    logic                              flip;
    logic signed [pre_pkg::QUAT_W+1:0] q_adj, q_d;
    logic signed [pre_pkg::DIFF_W-1:0] diff_k;
    logic [1:0]                        qi;
    logic [pre_pkg::GAIN_W-1:0]        gain_new_k, gain_old_k;
    logic signed [MW-1:0]              abs_prod;

    assign qi    = 2'(k_reg - pre_pkg::CH_W'(3));
    assign lq_w  = first_reg ? q_reg[0] : last_q_reg[0];
    assign lq_k  = first_reg ? q_reg[qi] : last_q_reg[qi];
    assign q_k   = q_reg[qi];
    // negate the current quaternion when w changes sign; zero never flips
    assign flip  = (q_reg[0] != '0) && (lq_w != '0) && (q_reg[0][15] != lq_w[15]);
    assign q_adj = flip ? -(pre_pkg::QUAT_W+2)'(q_k) : (pre_pkg::QUAT_W+2)'(q_k);
    assign q_d   = q_adj - (pre_pkg::QUAT_W+2)'(lq_k);

    always_comb
    begin
        if (k_reg < pre_pkg::CH_W'(3))
            diff_k = pre_pkg::DIFF_W'(pos_reg[k_reg[1:0]])
                   - pre_pkg::DIFF_W'(last_pos_reg[k_reg[1:0]]);
        else
            diff_k = pre_pkg::DIFF_W'(q_d) <<< 2;
    end

    always_comb
    begin
        if (k_reg < pre_pkg::CH_W'(2))
        begin
            gain_new_k = xy_gain_new_reg;
            gain_old_k = xy_gain_old_reg;
        end
        else if (k_reg == pre_pkg::CH_W'(2))
        begin
            gain_new_k = z_gain_new_reg;
            gain_old_k = z_gain_old_reg;
        end
        else
        begin
            gain_new_k = rot_gain_new_reg;
            gain_old_k = rot_gain_old_reg;
        end
    end

    assign abs_prod = mul_prod[MW-1] ? -mul_prod : mul_prod;

    // Body rate term: entry of W(q) times a quaternion rate
    pre_pkg::w_ent_t                   w_e;
    logic signed [pre_pkg::QUAT_W-1:0] w_q;
    logic signed [pre_pkg::QUAT_W:0]   w_q_ext;
    logic [pre_pkg::QUAT_W:0]          w_mag;
    logic                              w_neg;
    logic signed [MW-1:0]              qd_j;
    logic [pre_pkg::CH_W-1:0]          qd_idx;

    assign w_e     = pre_pkg::w_entry(i_reg, j_reg);
    assign w_q     = q_reg[w_e.idx];
    assign w_q_ext = (pre_pkg::QUAT_W+1)'(w_q);
    assign w_mag   = w_q[pre_pkg::QUAT_W-1] ? -w_q_ext : w_q_ext;
    assign w_neg   = w_e.neg ^ w_q[pre_pkg::QUAT_W-1];
    assign qd_idx  = pre_pkg::CH_W'(j_reg) + pre_pkg::CH_W'(3);
    assign qd_j    = MW'(new_rate_reg[qd_idx]);

    // Sum of the two filter terms
    logic signed [MW-1:0] res_s, sum_s, acc_s, body_s;
    assign res_s  = MW'({1'b0, res_reg});
    assign sum_s  = (neg_reg ? -res_s : res_s) + MW'(old_term_reg);
    assign acc_s  = MW'(acc_reg);
    assign body_s = pre_pkg::trunc_shr(acc_s, 13);

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        mul_ctl     = '{start: 1'b0, len: pre_pkg::LEN_W'(16)};
        mul_a       = MW'(diff_k);
        mul_b       = pre_pkg::MUL_B_W'(gain_new_k);
        div_start   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_CH;
            end
            S_CH:
            begin
                if ((k_reg < pre_pkg::CH_W'(3) && first_reg) || !run_reg)
                begin
                    if (k_reg == pre_pkg::CH_W'(pre_pkg::NUM_CH - 1))
                        state_next = S_RSTART;
                end
                else
                begin
                    mul_ctl.start = 1'b1;
                    state_next    = S_MUL1;
                end
            end
            S_MUL1:
            begin
                if (!mul_busy)
                begin
                    mul_ctl = '{start: 1'b1, len: pre_pkg::LEN_W'(pre_pkg::MUL_B_W)};
                    mul_a   = abs_prod;
                    mul_b   = pre_pkg::US_PER_S;
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                if (!mul_busy)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    mul_ctl.start = 1'b1;
                    mul_a         = MW'(last_rate_reg[k_reg]);
                    mul_b         = pre_pkg::MUL_B_W'(gain_old_k);
                    state_next    = S_MUL3;
                end
            end
            S_MUL3:
            begin
                if (!mul_busy)
                    state_next = S_SUM;
            end
            S_SUM:
            begin
                if (k_reg == pre_pkg::CH_W'(pre_pkg::NUM_CH - 1))
                    state_next = S_RSTART;
                else
                    state_next = S_CH;
            end
            S_RSTART:
            begin
                mul_ctl.start = 1'b1;
                mul_a         = w_neg ? -qd_j : qd_j;
                mul_b         = pre_pkg::MUL_B_W'(w_mag);
                state_next    = S_RMUL;
            end
            S_RMUL:
            begin
                if (!mul_busy)
                    state_next = (j_reg == 2'd3) ? S_RFIN : S_RSTART;
            end
            S_RFIN:
            begin
                state_next = (i_reg == 2'd2) ? S_OUT : S_RSTART;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            k_reg          <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            seen_first_reg <= 1'b0;
            first_reg      <= 1'b0;
            run_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            for (int n = 0; n < pre_pkg::NUM_CH; n++)
                last_rate_reg[n] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // drop the taken result unless a new one replaces it in this cycle
            if (m_tvalid_reg && m_tready && !(state_reg == S_OUT && out_free))
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        first_reg <= !seen_first_reg;
                        run_reg   <= s_tdata[179:160] > min_interval_reg;
                        k_reg     <= '0;
                        i_reg     <= '0;
                        j_reg     <= '0;
                    end
                end
                S_CH:
                begin
                    // skipped channels advance here
                    if ((k_reg < pre_pkg::CH_W'(3) && first_reg) || !run_reg)
                        k_reg <= k_reg + pre_pkg::CH_W'(1);
                end
                S_SUM:
                    k_reg <= k_reg + pre_pkg::CH_W'(1);
                S_RMUL:
                begin
                    if (!mul_busy)
                        j_reg <= j_reg + 2'd1;
                end
                S_RFIN:
                    i_reg <= i_reg + 2'd1;
                S_OUT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg   <= 1'b1;
                        seen_first_reg <= 1'b1;
                        for (int n = 0; n < pre_pkg::NUM_CH; n++)
                            last_rate_reg[n] <= new_rate_reg[n];
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    pos_reg[0] <= s_tdata[31:0];
                    pos_reg[1] <= s_tdata[63:32];
                    pos_reg[2] <= s_tdata[95:64];
                    q_reg[0]   <= s_tdata[111:96];
                    q_reg[1]   <= s_tdata[127:112];
                    q_reg[2]   <= s_tdata[143:128];
                    q_reg[3]   <= s_tdata[159:144];
                    dt_reg     <= s_tdata[179:160];
                    acc_reg    <= '0;
                end
            end
            S_CH:
            begin
                // first sample zeroes velocity, a short interval holds the rate
                if (k_reg < pre_pkg::CH_W'(3) && first_reg)
                    new_rate_reg[k_reg] <= '0;
                else if (!run_reg)
                    new_rate_reg[k_reg] <= last_rate_reg[k_reg];
            end
            S_MUL1:
            begin
                if (!mul_busy)
                    neg_reg <= mul_prod[MW-1];
            end
            S_DIV:
            begin
                if (!div_busy)
                    res_reg <= div_quot;
            end
            S_MUL3:
            begin
                if (!mul_busy)
                    old_term_reg <= pre_pkg::TERM_W'(pre_pkg::trunc_shr(mul_prod, 16));
            end
            S_SUM:
                new_rate_reg[k_reg] <= pre_pkg::sat32(sum_s);
            S_RMUL:
            begin
                if (!mul_busy)
                    acc_reg <= acc_reg + pre_pkg::ACC_W'(mul_prod);
            end
            S_RFIN:
            begin
                body_rate_reg[i_reg] <= pre_pkg::sat32(body_s);
                acc_reg              <= '0;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    for (int n = 0; n < 3; n++)
                    begin
                        out_vel_reg[n]  <= new_rate_reg[n];
                        out_rate_reg[n] <= body_rate_reg[n];
                        last_pos_reg[n] <= pos_reg[n];
                    end
                    for (int n = 0; n < 4; n++)
                        last_q_reg[n] <= q_reg[n];
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_rate_reg[2], out_rate_reg[1], out_rate_reg[0],
                       out_vel_reg[2], out_vel_reg[1], out_vel_reg[0]};

    // The multiplier never takes a new request while it is still shifting
    assert property (@(posedge clk) disable iff (!rst_n) mul_ctl.start |-> !mul_busy)
        else $error("multiplier restarted while busy");

    // The divider is launched only when idle
    assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // An accepted item starts the channel sweep in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_CH))
        else $error("accepted item did not start processing");

    // A new result appears only out of the output stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside the output stage");

endmodule
